[sv/drks_pkg.sv]
// Package with shared widths, codes and types of the k-th smallest unit.
package drks_pkg;

  localparam int POSITIONS_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 16;

  localparam int POS_W  = 10;
  localparam int VAL_W  = 16;
  localparam int RANK_W = 11;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 11;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OVER = 2'd1,
    STATUS_ZERO = 2'd2,
    STATUS_BAD  = 2'd3
  } status_e;

  typedef struct packed {
    logic done;
    logic over;
  } sel_result_t;

endpackage

[sv/drks_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module drks_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/drks_select.sv]
// Radix-select sequencer that scans the value memory once for the total count and then once per value bit.
module drks_select import drks_pkg::*; #(
  parameter int POSITIONS  = POSITIONS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [AW-1:0]         lo_i,
  input  logic [AW-1:0]         hi_i,
  input  logic [RANK_W-1:0]     rank_i,
  output logic                  rd_en_o,
  output logic [AW-1:0]         rd_addr_o,
  input  logic [VALUE_BITS:0]   rd_data_i,
  output logic [VALUE_BITS-1:0] value_o,
  output sel_result_t           res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EVAL
  } sel_state_e;

  sel_state_e            state_q;
  logic [AW-1:0]         addr_q;
  logic [AW-1:0]         lo_q;
  logic [AW-1:0]         hi_q;
  logic [RANK_W-1:0]     rk_q;
  logic [CNT_W-1:0]      count_q;
  logic [VALUE_BITS-1:0] pfx_q;
  logic [VALUE_BITS-1:0] mask_q;
  logic [VALUE_BITS-1:0] sel_q;
  logic                  rd_vld_q;
  logic                  done_q;
  logic                  over_q;

  logic                  match;
  logic                  above;
  logic [VALUE_BITS-1:0] sel_next;

  assign match = rd_data_i[VALUE_BITS] &&
                 (((rd_data_i[VALUE_BITS-1:0] ^ pfx_q) & mask_q) == '0);
  assign above    = RANK_W'(rk_q) > RANK_W'(count_q);
  assign sel_next = sel_q >> 1;

  assign rd_en_o   = (state_q == S_SCAN);
  assign rd_addr_o = addr_q;
  assign value_o   = pfx_q;
  assign res_o     = '{done: done_q, over: over_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      addr_q   <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      rk_q     <= '0;
      count_q  <= '0;
      pfx_q    <= '0;
      mask_q   <= '0;
      sel_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      over_q   <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN);
      if (rd_vld_q && match) begin
        count_q <= CNT_W'(count_q + CNT_W'(1));
      end
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            lo_q    <= lo_i;
            hi_q    <= hi_i;
            addr_q  <= lo_i;
            rk_q    <= rank_i;
            count_q <= '0;
            pfx_q   <= '0;
            mask_q  <= '0;
            sel_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (addr_q == hi_q) begin
            state_q <= S_DRAIN;
          end else begin
            addr_q <= AW'(addr_q + AW'(1));
          end
        end
        S_DRAIN: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          addr_q  <= lo_q;
          count_q <= '0;
          state_q <= S_SCAN;
          if (sel_q == '0) begin
            if (above) begin
              done_q  <= 1'b1;
              over_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              sel_q  <= {1'b1, {(VALUE_BITS-1){1'b0}}};
              mask_q <= {1'b1, {(VALUE_BITS-1){1'b0}}};
            end
          end else begin
            if (above) begin
              rk_q  <= RANK_W'(rk_q - RANK_W'(count_q));
              pfx_q <= pfx_q | sel_q;
            end
            if (sel_q[0]) begin
              done_q  <= 1'b1;
              over_q  <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              sel_q  <= sel_next;
              mask_q <= mask_q | sel_next;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/dynamic_range_kth_smallest_unit.sv]
// Top level of the dynamic range k-th smallest unit: config, clearing, memory and result.
//
// Channel   Direction  Handshake                 Payload
// in        request    in_valid_i / in_ready_o   kind, position, new_value, left_pos,
//                                                right_pos, rank
// out       response   out_valid_o / out_ready_i kth_value, status
// cfg       write      cfg_we_i                  cfg_wdata_i (position_count)
//
// A query with a bad range or rank zero makes no scan. Any other query makes up to
// VALUE_BITS + 1 scans of the range through the one memory read port; a rank above the
// count ends after the first scan. After reset every memory position is cleared with
// in_ready_o low. A finished query waits for the output register to free up.
module dynamic_range_kth_smallest_unit import drks_pkg::*; #(
  parameter int POSITIONS  = POSITIONS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [VAL_W-1:0]  new_value_i,
  input  logic [POS_W-1:0]  left_pos_i,
  input  logic [POS_W-1:0]  right_pos_i,
  input  logic [RANK_W-1:0] rank_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VAL_W-1:0]  kth_value_o,
  output logic [1:0]        status_o
);

  localparam int AW      = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int LIM_W   = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam int WIDE_W  = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;
  localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'({VALUE_BITS{1'b1}});

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY,
    ST_RESP
  } top_state_e;

  top_state_e        state_q;
  logic [AW-1:0]     clr_addr_q;
  logic [LIM_W-1:0]  pos_count_q;
  logic [VAL_W-1:0]  res_value_q;
  status_e           res_status_q;
  logic              out_valid_q;
  logic [VAL_W-1:0]  kth_value_q;
  status_e           status_q;

  logic [LIM_W-1:0]      pos_max;
  logic [LIM_W-1:0]      limit;
  logic                  accept;
  logic                  write_ok;
  logic                  bad_range;
  logic                  start;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS:0]   ram_wdata;
  logic [WIDE_W-1:0]     new_wide;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS:0]   rd_data;
  logic [VALUE_BITS-1:0] sel_value;
  logic [WIDE_W-1:0]     sel_wide;
  sel_result_t           sel_res;
  logic                  out_free;

  assign pos_max   = LIM_W'(POSITIONS);
  assign limit     = (pos_count_q > pos_max) ? pos_max : pos_count_q;
  assign accept    = in_valid_i && in_ready_o;
  assign write_ok  = LIM_W'(position_i) < limit;
  assign bad_range = (left_pos_i > right_pos_i) || (LIM_W'(right_pos_i) >= limit);
  assign start     = accept && (kind_i == KIND_QUERY) && !bad_range && (rank_i != '0);
  assign new_wide  = WIDE_W'(new_value_i);
  assign sel_wide  = WIDE_W'(sel_value);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(position_i);
    ram_wdata = {1'b1, new_wide[VALUE_BITS-1:0]};
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (accept && (kind_i == KIND_WRITE) && write_ok) begin
      ram_we = 1'b1;
    end
  end

  drks_ram #(
    .WIDTH (VALUE_BITS + 1),
    .DEPTH (POSITIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  drks_select #(
    .POSITIONS  (POSITIONS),
    .VALUE_BITS (VALUE_BITS)
  ) u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .lo_i      (AW'(left_pos_i)),
    .hi_i      (AW'(right_pos_i)),
    .rank_i    (rank_i),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .value_o   (sel_value),
    .res_o     (sel_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      pos_count_q  <= LIM_W'(POSITIONS);
      res_value_q  <= '0;
      res_status_q <= STATUS_OK;
      out_valid_q  <= 1'b0;
      kth_value_q  <= '0;
      status_q     <= STATUS_OK;
    end else begin
      if (cfg_we_i) begin
        pos_count_q <= LIM_W'(cfg_wdata_i);
      end
      if (out_valid_q && out_ready_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (clr_addr_q == AW'(POSITIONS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_addr_q <= AW'(clr_addr_q + AW'(1));
          end
        end
        ST_IDLE: begin
          if (accept && (kind_i == KIND_QUERY)) begin
            if (bad_range) begin
              res_value_q  <= '0;
              res_status_q <= STATUS_BAD;
              state_q      <= ST_RESP;
            end else if (rank_i == '0) begin
              res_value_q  <= '0;
              res_status_q <= STATUS_ZERO;
              state_q      <= ST_RESP;
            end else begin
              state_q <= ST_BUSY;
            end
          end
        end
        ST_BUSY: begin
          if (sel_res.done) begin
            if (sel_res.over) begin
              res_value_q  <= MAX_WIDE[VAL_W-1:0];
              res_status_q <= STATUS_OVER;
            end else begin
              res_value_q  <= sel_wide[VAL_W-1:0];
              res_status_q <= STATUS_OK;
            end
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kth_value_q <= res_value_q;
            status_q    <= res_status_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_value_q;
  assign status_o    = status_q;

  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_res.done |-> (state_q == ST_BUSY))
    else $error("select result outside of a running query");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !ram_we)
    else $error("memory write during a range scan");

  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_BUSY) && !sel_res.done)
    else $error("query start did not enter the busy state");

endmodule

[test/drks_result_checker.sv]
// Checker for the k-th smallest unit: mirrors the array, predicts each query answer and compares.
`timescale 1ns / 1ps

module drks_result_checker import drks_pkg::*; #(
  parameter int POSITIONS = POSITIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic              kind_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [VAL_W-1:0]  new_value_i,
  input  logic [POS_W-1:0]  left_pos_i,
  input  logic [POS_W-1:0]  right_pos_i,
  input  logic [RANK_W-1:0] rank_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [VAL_W-1:0]  kth_value_o,
  input  logic [1:0]        status_o,
  output int                fail_count_o,
  output int                pending_o,
  output int                writes_o,
  output int                answers_o
);

  typedef struct {
    logic [VAL_W-1:0] kth;
    status_e          st;
  } answer_t;

  answer_t          expected_answers[$];
  logic [VAL_W-1:0] value_mem [POSITIONS];
  bit               slot_used [POSITIONS];
  int unsigned      limit_reg;

  function automatic int unsigned usable_count();
    return (limit_reg > POSITIONS) ? POSITIONS : limit_reg;
  endfunction

  function automatic int unsigned count_prefix(int unsigned lo, int unsigned hi,
                                               int unsigned pfx, int b);
    int unsigned c;
    c = 0;
    for (int unsigned p = lo; p <= hi; p++) begin
      if (slot_used[p] && ((32'(value_mem[p]) >> b) == (pfx >> b))) c++;
    end
    return c;
  endfunction

  function automatic answer_t select_kth(int unsigned lo, int unsigned hi, int unsigned rk);
    answer_t     a;
    int unsigned pfx;
    int unsigned c;
    pfx = 0;
    if (lo > hi || hi >= usable_count()) begin
      a.kth = '0;
      a.st  = STATUS_BAD;
    end else if (rk == 0) begin
      a.kth = '0;
      a.st  = STATUS_ZERO;
    end else if (rk > count_prefix(lo, hi, 0, VAL_W)) begin
      a.kth = '1;
      a.st  = STATUS_OVER;
    end else begin
      for (int b = VAL_W - 1; b >= 0; b--) begin
        c = count_prefix(lo, hi, pfx, b);
        if (rk > c) begin
          rk  = rk - c;
          pfx = pfx | (32'd1 << b);
        end
      end
      a.kth = pfx[VAL_W-1:0];
      a.st  = STATUS_OK;
    end
    return a;
  endfunction

  task automatic note_mismatch(input string what, input answer_t want);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("[%0t] %s: expected kth_value %h status %0d, got kth_value %h status %0d",
               $realtime, what, want.kth, want.st, kth_value_o, status_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      expected_answers.delete();
      limit_reg = POSITIONS;
      for (int p = 0; p < POSITIONS; p++) slot_used[p] = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      writes_o     = 0;
      answers_o    = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        answers_o++;
        if (expected_answers.size() == 0) begin
          want.kth = 'x;
          want.st  = STATUS_OK;
          note_mismatch("Unexpected answer", want);
        end else begin
          want = expected_answers.pop_front();
          if (kth_value_o !== want.kth || status_o !== want.st) begin
            note_mismatch("Wrong answer", want);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (kind_i == KIND_WRITE) begin
          writes_o++;
          if (position_i < usable_count()) begin
            value_mem[position_i] = new_value_i;
            slot_used[position_i] = 1'b1;
          end
        end else begin
          expected_answers.push_back(select_kth(left_pos_i, right_pos_i, rank_i));
        end
      end
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      pending_o = expected_answers.size();
    end
  end

endmodule

[test/dynamic_range_kth_smallest_unit_tb.sv]
// Testbench top for the k-th smallest unit: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module dynamic_range_kth_smallest_unit_tb import drks_pkg::*;;

  localparam int POSITIONS     = POSITIONS_DEF;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_CYCLES  = 400;
  localparam int CYCLE_LIMIT   = 10000000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              kind_i;
  logic [POS_W-1:0]  position_i;
  logic [VAL_W-1:0]  new_value_i;
  logic [POS_W-1:0]  left_pos_i;
  logic [POS_W-1:0]  right_pos_i;
  logic [RANK_W-1:0] rank_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [VAL_W-1:0]  kth_value_o;
  logic [1:0]        status_o;

  int fail_count;
  int pending;
  int writes_seen;
  int answers_seen;
  int cycle_count;
  bit quiet;
  bit stall_req;

  dynamic_range_kth_smallest_unit #(
    .POSITIONS  (POSITIONS),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .new_value_i (new_value_i),
    .left_pos_i  (left_pos_i),
    .right_pos_i (right_pos_i),
    .rank_i      (rank_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kth_value_o (kth_value_o),
    .status_o    (status_o)
  );

  drks_result_checker #(
    .POSITIONS (POSITIONS)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .new_value_i  (new_value_i),
    .left_pos_i   (left_pos_i),
    .right_pos_i  (right_pos_i),
    .rank_i       (rank_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kth_value_o  (kth_value_o),
    .status_o     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .writes_o     (writes_seen),
    .answers_o    (answers_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d answers outstanding.", cycle_count, pending);
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= quiet || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  task automatic send_req(input logic kind, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                          input logic [POS_W-1:0] hi, input logic [RANK_W-1:0] rk);
    while (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    position_i  <= pos;
    new_value_i <= val;
    left_pos_i  <= lo;
    right_pos_i <= hi;
    rank_i      <= rk;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_at(input int pos, input int val);
    send_req(KIND_WRITE, POS_W'(pos), VAL_W'(val), POS_W'($urandom), POS_W'($urandom),
             RANK_W'($urandom));
  endtask

  task automatic query_range(input int lo, input int hi, input int rk);
    send_req(KIND_QUERY, POS_W'($urandom), VAL_W'($urandom), POS_W'(lo), POS_W'(hi),
             RANK_W'(rk));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_limit(input int count);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(count);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_item(input int span, input int wide_pct);
    int lo;
    int hi;
    int w;
    int cap;
    int rk;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      w = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 15) : $urandom;
      if ($urandom_range(0, 9) == 0) write_at($urandom_range(0, 1023), w);
      else write_at($urandom_range(0, span - 1), w);
    end else begin
      if ($urandom_range(0, 99) < wide_pct) lo = $urandom_range(0, 1023);
      else lo = $urandom_range(0, span - 1);
      w   = $urandom_range(0, 23);
      cap = (lo < span) ? span - 1 : 1023;
      hi  = (lo + w > cap) ? cap : lo + w;
      roll = $urandom_range(0, 99);
      if (roll < 8) rk = 0;
      else if (roll < 16) rk = $urandom_range(0, 2047);
      else rk = $urandom_range(1, w + 3);
      roll = $urandom_range(0, 99);
      if (roll < 6 && lo != hi) begin
        w  = lo;
        lo = hi;
        hi = w;
      end else if (roll < 12) begin
        hi = $urandom_range(0, 1023);
      end
      query_range(lo, hi, rk);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_WRITE;
    position_i  = '0;
    new_value_i = '0;
    left_pos_i  = '0;
    right_pos_i = '0;
    rank_i      = '0;
    quiet       = 1'b0;
    stall_req   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_at(0, 16'h0000);
    write_at(1, 16'hFFFF);
    write_at(2, 5);
    write_at(3, 5);
    write_at(1023, 7);
    write_at(2, 9);
    query_range(0, 3, 1);
    query_range(0, 3, 3);
    query_range(0, 3, 4);
    query_range(0, 3, 5);
    query_range(0, 3, 0);
    query_range(3, 2, 1);
    query_range(1023, 1023, 1);
    query_range(500, 510, 1);
    query_range(0, 1023, 2047);
    query_range(0, 1023, 3);

    set_limit(1);
    write_at(1, 3);
    write_at(0, 16'h8000);
    query_range(0, 0, 1);
    query_range(0, 1, 1);

    set_limit(0);
    write_at(0, 1);
    query_range(0, 0, 1);

    set_limit(2047);
    query_range(0, 3, 2);
    write_at(1023, 16'h1234);
    query_range(1020, 1023, 1);

    set_limit(40);
    for (int i = 0; i < 40; i++) begin
      if (i == 10) stall_req = 1'b1;
      if (i >= 10 && i < 20) query_range($urandom_range(0, 7), $urandom_range(8, 20),
                                         $urandom_range(1, 6));
      else random_item(40, 10);
    end

    set_limit(1024);
    quiet = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i == 20) quiet = 1'b0;
      if (i == 30) drain();
      random_item(64, 15);
    end

    drain();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d write requests and %0d query answers in %0d cycles,",
             writes_seen, answers_seen, cycle_count);
    $display("across position_count settings 1024, 1, 0, 2047, 40 and 1024 again.");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/drks_pkg.sv
sv/drks_ram.sv
sv/drks_select.sv
sv/dynamic_range_kth_smallest_unit.sv
test/drks_result_checker.sv
test/dynamic_range_kth_smallest_unit_tb.sv
